@@ rtl/core/sm4_pkg.sv @@
// SM4 shared definitions: state and register codes, S-box table, CK/FK constants
// and the word-level helper functions used by the round unit and the top level.
// No dependencies.
package sm4_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int RK_AW      = $clog2(NUM_ROUNDS);
    localparam int CFG_IDX_W  = 1;
    localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(NUM_ROUNDS - 1);

    typedef logic [3:0][31:0] word4_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREP,
        ST_RUN,
        ST_DRAIN
    } sm4_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;

    localparam logic [7:0] SBOX [256] = '{
        8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
        8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
        8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
        8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
        8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
        8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
        8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
        8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
        8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
        8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
        8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
        8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
        8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
        8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
        8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
        8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
        8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
        8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
        8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
        8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
        8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
        8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
        8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
        8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
        8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
        8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
        8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
        8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
        8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
        8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
    };

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // byte-wise S-box substitution
    function automatic logic [31:0] sbox_word(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // CK[i] byte j = 7 * (4i + j) mod 256
    function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] idx);
        logic [31:0] w;
        logic [7:0]  n;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            n = {1'b0, idx, 2'(j)};
            w[31-8*j -: 8] = 8'(n * 8'd7);
        end
        return w;
    endfunction

endpackage

@@ rtl/core/sm4_block_cipher_unit.sv @@
// SM4 block cipher top level: key registers, control FSM, block/key word
// registers and output register. Depends on sm4_pkg, sm4_rk_ram, sm4_round_unit.
//
// Usage:
//   Load the 128-bit key through the write port (cfg_index 0: key_high,
//   1: key_low) while the block is idle. A key write marks the round keys stale.
//   Input transactions (s_valid/s_ready) carry s_action (0 encrypt, 1 decrypt)
//   and the block as two 64-bit halves; each produces one output transaction
//   (m_valid/m_ready) with the 128-bit result.
//   From input acceptance to m_valid a block passes key fetch (ST_PREP),
//   32 rounds on the single shared round unit (ST_RUN) and output load
//   (ST_DRAIN). The first block after a key change runs the key schedule
//   (ST_EXPAND) beforehand, which writes one round key per cycle into the
//   round key RAM. A new block is taken only in the idle state, in which
//   s_ready is high for the next transaction, once the last one is loaded.
//   s_ready is high only while no block is in flight. A finished result waits
//   in the output register; if the receiver stalls, the next block is still
//   taken and computed, and holds before its output load until m_ready.
//   Reset clears control state and marks round keys stale; the round key RAM
//   is not cleared, as it is always written by the key schedule before use.
module sm4_block_cipher_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_action,
    input  logic [63:0]                  s_block_high,
    input  logic [63:0]                  s_block_low,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [63:0]                  m_result_high,
    output logic [63:0]                  m_result_low
);
    import sm4_pkg::*;

    sm4_state_t       state_reg, state_next;
    logic [63:0]      key_high_reg, key_low_reg;
    logic             keys_ready_reg;
    logic [RK_AW-1:0] cnt_reg;
    logic             dec_reg;
    word4_t           x_reg, k_reg;
    logic             m_valid_reg;
    logic [63:0]      res_high_reg, res_low_reg;

    logic             accept;
    logic             load_out;
    logic             rk_we;
    logic [RK_AW-1:0] rd_idx;
    logic [RK_AW-1:0] rk_raddr;
    logic [31:0]      rk_rdata;
    logic             key_mode;
    word4_t           rnd_w;
    logic [31:0]      rnd_rk;
    logic [31:0]      rnd_new;

    // FSM next state and control
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        rk_we      = 1'b0;
        rd_idx     = RK_AW'(cnt_reg + RK_AW'(1));
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = keys_ready_reg ? ST_PREP : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                rk_we = 1'b1;
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                rd_idx     = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign accept   = s_valid && s_ready;
    // decryption walks the round keys from the top down
    assign rk_raddr = dec_reg ? ~rd_idx : rd_idx;
    assign key_mode = (state_reg == ST_EXPAND);
    assign rnd_w    = key_mode ? k_reg : x_reg;
    assign rnd_rk   = key_mode ? ck_word(cnt_reg) : rk_rdata;

    sm4_round_unit u_round (
        .key_mode (key_mode),
        .w_in     (rnd_w),
        .rk       (rnd_rk),
        .w_new    (rnd_new)
    );

    sm4_rk_ram u_rk_ram (
        .aclk    (aclk),
        .wr_en   (rk_we),
        .wr_addr (cnt_reg),
        .wr_data (rnd_new),
        .rd_addr (rk_raddr),
        .rd_data (rk_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            keys_ready_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                keys_ready_reg <= 1'b0;
                unique case (cfg_reg_t'(cfg_index))
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    default:      key_high_reg <= key_high_reg;
                endcase
            end else if (state_reg == ST_EXPAND && cnt_reg == LAST_ROUND) begin
                keys_ready_reg <= 1'b1;
            end

            if (accept || state_reg == ST_PREP) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_EXPAND || state_reg == ST_RUN) begin
                cnt_reg <= RK_AW'(cnt_reg + RK_AW'(1));
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            dec_reg  <= s_action;
            x_reg[0] <= s_block_high[63:32];
            x_reg[1] <= s_block_high[31:0];
            x_reg[2] <= s_block_low[63:32];
            x_reg[3] <= s_block_low[31:0];
            k_reg[0] <= key_high_reg[63:32] ^ FK0;
            k_reg[1] <= key_high_reg[31:0]  ^ FK1;
            k_reg[2] <= key_low_reg[63:32]  ^ FK2;
            k_reg[3] <= key_low_reg[31:0]   ^ FK3;
        end else if (state_reg == ST_EXPAND) begin
            k_reg <= {rnd_new, k_reg[3], k_reg[2], k_reg[1]};
        end else if (state_reg == ST_RUN) begin
            x_reg <= {rnd_new, x_reg[3], x_reg[2], x_reg[1]};
        end
        if (load_out) begin
            res_high_reg <= {x_reg[3], x_reg[2]};
            res_low_reg  <= {x_reg[1], x_reg[0]};
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_high = res_high_reg;
    assign m_result_low  = res_low_reg;

    a_stale_keys_expand: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !keys_ready_reg) |=> state_reg == ST_EXPAND)
        else $error("block with stale round keys skipped key schedule");

    a_run_has_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && !cfg_we && !$past(cfg_we)) |-> keys_ready_reg)
        else $error("rounds running without expanded keys");

    a_last_round_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg == LAST_ROUND) |=> state_reg == ST_DRAIN)
        else $error("round count did not end in output load");

    a_valid_from_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DRAIN))
        else $error("result presented outside output load");

    a_no_write_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN || state_reg == ST_PREP) |-> !rk_we)
        else $error("round key RAM written while being read for rounds");

endmodule

@@ rtl/core/sm4_rk_ram.sv @@
// Round key store: 32 x 32-bit synchronous RAM, one write and one read port,
// read data registered. Depends on sm4_pkg.
module sm4_rk_ram (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [sm4_pkg::RK_AW-1:0] wr_addr,
    input  logic [31:0]              wr_data,
    input  logic [sm4_pkg::RK_AW-1:0] rd_addr,
    output logic [31:0]              rd_data
);
    import sm4_pkg::*;

    logic [31:0] mem [NUM_ROUNDS];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sm4_round_unit.sv @@
// Shared SM4 round: new word = w0 ^ T(w1 ^ w2 ^ w3 ^ rk), with the linear layer
// L (data rounds) or L' (key schedule) chosen by key_mode. Depends on sm4_pkg.
module sm4_round_unit (
    input  logic            key_mode,
    input  sm4_pkg::word4_t w_in,
    input  logic [31:0]     rk,
    output logic [31:0]     w_new
);
    import sm4_pkg::*;

    logic [31:0] t_in;
    logic [31:0] sub;
    logic [31:0] lin;

    always_comb begin
        t_in = w_in[1] ^ w_in[2] ^ w_in[3] ^ rk;
        sub  = sbox_word(t_in);
        if (key_mode) begin
            lin = sub ^ rotl32(sub, 13) ^ rotl32(sub, 23);
        end else begin
            lin = sub ^ rotl32(sub, 2) ^ rotl32(sub, 10) ^ rotl32(sub, 18)
                ^ rotl32(sub, 24);
        end
        w_new = w_in[0] ^ lin;
    end

endmodule

@@ tb/tb_sm4_block_cipher_unit.sv @@
// Self-checking testbench for sm4_block_cipher_unit: directed and random SM4 traffic,
// with predictions from an in-bench cipher model and scoreboarded result checks.
// Depends on sm4_pkg (S-box, FK constants, register codes) and the DUT RTL.
module tb_sm4_block_cipher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sm4_pkg::*;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;
    localparam int   ITEMS_PER_PROFILE = 338;
    localparam int   PAUSE_EVERY       = 85;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_block_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_HIGH;
    logic [63:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = ACT_ENCRYPT;
    logic [63:0]          s_block_high = '0;
    logic [63:0]          s_block_low = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [63:0]          m_result_high;
    logic [63:0]          m_result_low;

    // cipher model state
    logic [63:0] key_high_q = '0;
    logic [63:0] key_low_q = '0;
    logic [31:0] round_keys [32];
    bit          round_keys_valid = 1'b0;

    cipher_block_t pending_blocks [$];

    int error_count = 0;
    int encrypt_count = 0;
    int decrypt_count = 0;
    int key_write_count = 0;
    int result_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_left = 0;

    sm4_block_cipher_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_block_high  (s_block_high),
        .s_block_low   (s_block_low),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_high (m_result_high),
        .m_result_low  (m_result_low)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------- cipher model ----------------

    function automatic logic [31:0] rol(input logic [31:0] w, input int n);
        return (w << n) | (w >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_bytes(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] data_mix(input logic [31:0] w);
        logic [31:0] b;
        b = sub_bytes(w);
        return b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
    endfunction

    function automatic logic [31:0] key_mix(input logic [31:0] w);
        logic [31:0] b;
        b = sub_bytes(w);
        return b ^ rol(b, 13) ^ rol(b, 23);
    endfunction

    function automatic logic [31:0] schedule_const(input int i);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++)
            w = {w[23:0], 8'((4 * i + j) * 7)};
        return w;
    endfunction

    function automatic void expand_schedule();
        logic [31:0] k [4];
        logic [31:0] nk;
        k[0] = key_high_q[63:32] ^ FK0;
        k[1] = key_high_q[31:0] ^ FK1;
        k[2] = key_low_q[63:32] ^ FK2;
        k[3] = key_low_q[31:0] ^ FK3;
        for (int i = 0; i < 32; i++) begin
            nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ schedule_const(i));
            round_keys[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
        round_keys_valid = 1'b1;
    endfunction

    function automatic cipher_block_t cipher_block(input logic act, input logic [63:0] hi,
                                                   input logic [63:0] lo);
        logic [31:0] x [4];
        logic [31:0] rk;
        logic [31:0] nx;
        cipher_block_t r;
        if (!round_keys_valid)
            expand_schedule();
        x[0] = hi[63:32];
        x[1] = hi[31:0];
        x[2] = lo[63:32];
        x[3] = lo[31:0];
        for (int i = 0; i < 32; i++) begin
            rk = (act == ACT_DECRYPT) ? round_keys[31 - i] : round_keys[i];
            nx = x[0] ^ data_mix(x[1] ^ x[2] ^ x[3] ^ rk);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        r.hi = {x[3], x[2]};
        r.lo = {x[1], x[0]};
        return r;
    endfunction

    // ---------------- result checker and receiver stalls ----------------

    always @(posedge aclk) begin : result_check
        cipher_block_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_blocks.size() == 0) begin
                $error("unexpected result transaction: %h %h", m_result_high, m_result_low);
                error_count++;
            end else begin
                want = pending_blocks.pop_front();
                if (m_result_high !== want.hi) begin
                    $error("result_high: expected %h, got %h", want.hi, m_result_high);
                    error_count++;
                end
                if (m_result_low !== want.lo) begin
                    $error("result_low: expected %h, got %h", want.lo, m_result_low);
                    error_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(99) < recv_stall_pct) begin
            // mostly short stalls, now and then one longer than a full block
            stall_left = ($urandom_range(5) == 0) ? $urandom_range(60, 10) : $urandom_range(2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------- shared stimulus tasks ----------------

    // Leaves s_valid high after acceptance; the caller either sends again in the
    // same step or calls wait_drained.
    task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo,
                              output cipher_block_t res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap += ($urandom_range(7) == 0) ? $urandom_range(40, 10) : 1;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_block_high <= hi;
        s_block_low  <= lo;
        do @(posedge aclk); while (!s_ready);
        res = cipher_block(act, hi, lo);
        pending_blocks.push_back(res);
        if (act == ACT_DECRYPT)
            decrypt_count++;
        else
            encrypt_count++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_blocks.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_KEY_HIGH: key_high_q = val;
            REG_KEY_LOW:  key_low_q = val;
            default: ;
        endcase
        round_keys_valid = 1'b0;
        key_write_count++;
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        wait_drained();
        write_reg(REG_KEY_HIGH, hi);
        write_reg(REG_KEY_LOW, lo);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] key_half();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    // ---------------- tests ----------------

    // no key write yet: the all-zero reset key must be expanded on first use
    task automatic test_reset_key();
        cipher_block_t r;
        send_block(ACT_ENCRYPT, '0, '0, r);
        send_block(ACT_DECRYPT, '1, '1, r);
        send_block(ACT_ENCRYPT, rand64(), rand64(), r);
    endtask

    task automatic test_known_answer();
        cipher_block_t r;
        load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        r = cipher_block(ACT_ENCRYPT, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        if ({r.hi, r.lo} !== 128'h681EDF34D206965E86B3E94F536E4246) begin
            $error("known answer: expected %h, got %h",
                   128'h681EDF34D206965E86B3E94F536E4246, {r.hi, r.lo});
            error_count++;
        end
        send_block(ACT_ENCRYPT, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, r);
        send_block(ACT_DECRYPT, 64'h681EDF34D206965E, 64'h86B3E94F536E4246, r);
    endtask

    task automatic test_block_extremes();
        cipher_block_t r;
        send_block(ACT_ENCRYPT, '0, '0, r);
        send_block(ACT_DECRYPT, '1, '1, r);
        send_block(ACT_ENCRYPT, {16{4'h5}}, {16{4'hA}}, r);
        send_block(ACT_DECRYPT, {16{4'hA}}, {16{4'h5}}, r);
    endtask

    // one key half changed at a time, so stale round keys must be rebuilt
    task automatic test_partial_rekey();
        cipher_block_t r;
        wait_drained();
        write_reg(REG_KEY_LOW, rand64());
        send_block(ACT_ENCRYPT, rand64(), rand64(), r);
        wait_drained();
        write_reg(REG_KEY_HIGH, rand64());
        send_block(ACT_DECRYPT, rand64(), rand64(), r);
        wait_drained();
        write_reg(REG_KEY_HIGH, rand64());
        write_reg(REG_KEY_HIGH, rand64());
        send_block(ACT_ENCRYPT, rand64(), rand64(), r);
    endtask

    task automatic test_key_extremes();
        cipher_block_t r;
        load_key('0, '0);
        send_block(ACT_ENCRYPT, rand64(), rand64(), r);
        send_block(ACT_DECRYPT, rand64(), rand64(), r);
        load_key('1, '1);
        send_block(ACT_ENCRYPT, rand64(), rand64(), r);
        send_block(ACT_DECRYPT, rand64(), rand64(), r);
    endtask

    task automatic test_random_traffic();
        cipher_block_t r;
        cipher_block_t prev;
        logic          prev_act;
        logic          act;
        logic [63:0]   hi;
        logic [63:0]   lo;
        int unsigned   kind;
        prev.hi  = rand64();
        prev.lo  = rand64();
        prev_act = ACT_ENCRYPT;
        for (int profile = 0; profile < 4; profile++) begin
            wait_drained();
            case (profile)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            load_key(key_half(), key_half());
            for (int n = 0; n < ITEMS_PER_PROFILE; n++) begin
                if (n > 0 && n % PAUSE_EVERY == 0) begin
                    // hold off until the block is empty, sometimes rekey there
                    wait_drained();
                    case ($urandom_range(3))
                        0: write_reg(REG_KEY_HIGH, key_half());
                        1: write_reg(REG_KEY_LOW, key_half());
                        2: begin
                            write_reg(REG_KEY_HIGH, key_half());
                            write_reg(REG_KEY_LOW, key_half());
                        end
                        default: ;
                    endcase
                end
                kind = $urandom_range(99);
                if (kind < 30) begin
                    // round trip: invert the previous transaction's result
                    act = ~prev_act;
                    hi  = prev.hi;
                    lo  = prev.lo;
                end else if (kind < 42) begin
                    act = 1'($urandom_range(1));
                    hi  = 64'h1 << $urandom_range(63);
                    lo  = ~(64'h1 << $urandom_range(63));
                end else begin
                    act = 1'($urandom_range(1));
                    hi  = rand64();
                    lo  = rand64();
                end
                send_block(act, hi, lo, r);
                prev     = r;
                prev_act = act;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_key();
        test_known_answer();
        test_block_extremes();
        test_partial_rekey();
        test_key_extremes();
        test_random_traffic();

        wait_drained();
        // quiet period longer than one block's latency: nothing more may show up
        repeat (80) @(posedge aclk);

        $display("Run covered %0d encrypt and %0d decrypt transactions, %0d results,",
                 encrypt_count, decrypt_count, result_count);
        $display("%0d key register writes, four idle/stall profiles and drained pauses.",
                 key_write_count);
        if (error_count == 0 && pending_blocks.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending_blocks.size() != 0)
                $error("%0d expected results never arrived", pending_blocks.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
